// ===== hw/rtl/ifp_pkg.sv =====
// Shared types, sizes and token codes for the infix to postfix converter.
package ifp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_W     = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W     = 3;
  localparam int KIND_W      = 3;
  localparam int OP_W        = 2;
  localparam int OKIND_W     = 2;
  localparam int ERR_W       = 2;
  localparam int IN_DATA_W   = ((VALUE_W + OP_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((VALUE_W + OP_W + ERR_W + 7) / 8) * 8;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam cnt_t DEPTH_CNT = STACK_DEPTH[CNT_W-1:0];

  // input token kinds
  localparam logic [KIND_W-1:0] TK_OPERAND  = 3'd0;
  localparam logic [KIND_W-1:0] TK_OPERATOR = 3'd1;
  localparam logic [KIND_W-1:0] TK_OPEN     = 3'd2;
  localparam logic [KIND_W-1:0] TK_CLOSE    = 3'd3;
  localparam logic [KIND_W-1:0] TK_END      = 3'd4;

  // result kinds
  localparam logic [OKIND_W-1:0] RK_OPERAND  = 2'd0;
  localparam logic [OKIND_W-1:0] RK_OPERATOR = 2'd1;
  localparam logic [OKIND_W-1:0] RK_END      = 2'd2;
  localparam logic [OKIND_W-1:0] RK_ERROR    = 2'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CLOSE    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OPEN     = 2'd3;

  // stack entry marking an open parenthesis
  localparam entry_t ENTRY_OPEN = 3'd4;

  typedef struct packed {
    logic [OKIND_W-1:0] kind;
    logic [VALUE_W-1:0] value;
    logic [OP_W-1:0]    op;
    logic [ERR_W-1:0]   err;
  } res_t;

  typedef struct packed {
    logic valid;
    logic final_res;
    logic flush;
    res_t res;
  } ocmd_t;

  typedef struct packed {
    logic hold_v;
    logic out_free;
  } ostat_t;

  // times and divide bind tighter than plus and minus
  function automatic logic prec_hi(input logic [OP_W-1:0] op);
    prec_hi = op[1];
  endfunction

endpackage

// ===== hw/rtl/ifp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ifp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ifp_out.sv =====
// Result hold stage and output register; the hold stage defers tlast until the run ends.
module ifp_out (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ifp_pkg::ocmd_t                  cmd,
  output ifp_pkg::ostat_t                 stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ifp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [ifp_pkg::OKIND_W-1:0]     out_tuser,
  output logic                            out_tlast
);

  localparam int PAD_W = ifp_pkg::OUT_DATA_W - ifp_pkg::VALUE_W - ifp_pkg::OP_W
                         - ifp_pkg::ERR_W;

  logic           hold_v_r, hold_v_nxt;
  ifp_pkg::res_t  hold_r, hold_nxt;
  logic           out_v_r, out_v_nxt;
  ifp_pkg::res_t  out_res_r, out_res_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_free;

  assign out_free = !out_v_r || out_tready;

  always_comb begin
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_res_nxt  = out_res_r;
    out_last_nxt = out_last_r;
    if (cmd.flush) begin
      out_v_nxt    = 1'b1;
      out_res_nxt  = hold_r;
      out_last_nxt = 1'b1;
      hold_v_nxt   = 1'b0;
    end else if (cmd.valid && cmd.final_res) begin
      out_v_nxt    = 1'b1;
      out_res_nxt  = cmd.res;
      out_last_nxt = 1'b1;
    end else if (cmd.valid) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_res_nxt  = hold_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt = 1'b1;
      hold_nxt   = cmd.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    hold_r     <= hold_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign stat.hold_v   = hold_v_r;
  assign stat.out_free = out_free;

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_res_r.err, out_res_r.op, out_res_r.value};

endmodule

// ===== hw/rtl/ifp_ctrl.sv =====
// Token sequencer: operator stack pointer, stack RAM reads, pops and pushes.
module ifp_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ifp_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [ifp_pkg::KIND_W-1:0]      in_tuser,
  output logic                            ram_we,
  output ifp_pkg::ptr_t                   ram_waddr,
  output ifp_pkg::entry_t                 ram_wdata,
  output logic                            ram_re,
  output ifp_pkg::ptr_t                   ram_raddr,
  input  ifp_pkg::entry_t                 ram_rdata,
  output ifp_pkg::ocmd_t                  cmd,
  input  ifp_pkg::ostat_t                 stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_STOP = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  ifp_pkg::cnt_t                  count_r, count_nxt;
  logic [ifp_pkg::KIND_W-1:0]     kind_r, kind_nxt;
  logic [ifp_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [ifp_pkg::VALUE_W-1:0]    value_r, value_nxt;
  logic [ifp_pkg::ERR_W-1:0]      err_r, err_nxt;

  ifp_pkg::cnt_t                  cnt_dec;
  ifp_pkg::cnt_t                  cnt_dec2;
  logic                           top_open;
  logic                           pop_stop;
  logic                           term;
  logic                           can_emit;
  ifp_pkg::res_t                  term_res;
  logic                           term_push;

  assign cnt_dec   = count_r - ifp_pkg::cnt_t'(1);
  assign cnt_dec2  = count_r - ifp_pkg::cnt_t'(2);
  assign top_open  = ram_rdata == ifp_pkg::ENTRY_OPEN;
  assign pop_stop  = top_open ||
                     (!ifp_pkg::prec_hi(ram_rdata[ifp_pkg::OP_W-1:0]) &&
                      ifp_pkg::prec_hi(op_r));
  assign can_emit  = !stat.hold_v || stat.out_free;
  assign term      = (state_r == S_STOP) ||
                     (state_r == S_EVAL && kind_r == ifp_pkg::TK_OPERATOR && pop_stop);
  assign in_tready = state_r == S_IDLE;

  always_comb begin
    term_res  = '0;
    term_push = 1'b0;
    case (kind_r)
      ifp_pkg::TK_OPERAND: begin
        term_res.kind  = ifp_pkg::RK_OPERAND;
        term_res.value = value_r;
      end
      ifp_pkg::TK_OPERATOR: begin
        if (count_r >= ifp_pkg::DEPTH_CNT) begin
          term_res.kind = ifp_pkg::RK_ERROR;
          term_res.err  = ifp_pkg::ERR_OVERFLOW;
        end else begin
          term_push = 1'b1;
        end
      end
      ifp_pkg::TK_OPEN: begin
        term_res.kind = ifp_pkg::RK_ERROR;
        term_res.err  = ifp_pkg::ERR_OVERFLOW;
      end
      ifp_pkg::TK_CLOSE: begin
        term_res.kind = ifp_pkg::RK_ERROR;
        term_res.err  = ifp_pkg::ERR_CLOSE;
      end
      default: begin
        term_res.kind = ifp_pkg::RK_END;
        term_res.err  = err_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    kind_nxt  = kind_r;
    op_nxt    = op_r;
    value_nxt = value_r;
    err_nxt   = err_r;
    ram_we    = 1'b0;
    ram_waddr = count_r[ifp_pkg::PTR_W-1:0];
    ram_wdata = {1'b0, op_r};
    ram_re    = 1'b0;
    ram_raddr = cnt_dec[ifp_pkg::PTR_W-1:0];
    cmd       = '0;

    if (term) begin
      if (term_push) begin
        ram_we    = 1'b1;
        count_nxt = count_r + ifp_pkg::cnt_t'(1);
        state_nxt = stat.hold_v ? S_FIN : S_IDLE;
      end else if (stat.out_free) begin
        cmd.valid     = 1'b1;
        cmd.final_res = !stat.hold_v;
        cmd.res       = term_res;
        state_nxt     = stat.hold_v ? S_FIN : S_IDLE;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_nxt  = in_tuser;
            value_nxt = in_tdata[ifp_pkg::VALUE_W-1:0];
            op_nxt    = in_tdata[ifp_pkg::VALUE_W +: ifp_pkg::OP_W];
            err_nxt   = ifp_pkg::ERR_NONE;
            case (in_tuser)
              ifp_pkg::TK_OPERAND: begin
                state_nxt = S_STOP;
              end
              ifp_pkg::TK_OPERATOR: begin
                if (count_r == '0) begin
                  ram_we    = 1'b1;
                  ram_wdata = {1'b0, in_tdata[ifp_pkg::VALUE_W +: ifp_pkg::OP_W]};
                  count_nxt = ifp_pkg::cnt_t'(1);
                end else begin
                  ram_re    = 1'b1;
                  state_nxt = S_EVAL;
                end
              end
              ifp_pkg::TK_OPEN: begin
                if (count_r >= ifp_pkg::DEPTH_CNT) begin
                  state_nxt = S_STOP;
                end else begin
                  ram_we    = 1'b1;
                  ram_wdata = ifp_pkg::ENTRY_OPEN;
                  count_nxt = count_r + ifp_pkg::cnt_t'(1);
                end
              end
              ifp_pkg::TK_CLOSE, ifp_pkg::TK_END: begin
                if (count_r == '0) begin
                  state_nxt = S_STOP;
                end else begin
                  ram_re    = 1'b1;
                  state_nxt = S_EVAL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EVAL: begin
          if (top_open || can_emit) begin
            count_nxt = cnt_dec;
            if (!top_open) begin
              cmd.valid    = 1'b1;
              cmd.res.kind = ifp_pkg::RK_OPERATOR;
              cmd.res.op   = ram_rdata[ifp_pkg::OP_W-1:0];
            end else if (kind_r == ifp_pkg::TK_END) begin
              err_nxt = ifp_pkg::ERR_OPEN;
            end
            if (kind_r == ifp_pkg::TK_CLOSE && top_open) begin
              state_nxt = S_FIN;
            end else if (cnt_dec == '0) begin
              state_nxt = S_STOP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = cnt_dec2[ifp_pkg::PTR_W-1:0];
            end
          end
        end
        S_FIN: begin
          if (!stat.hold_v) begin
            state_nxt = S_IDLE;
          end else if (stat.out_free) begin
            cmd.flush = 1'b1;
            state_nxt = S_IDLE;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    kind_r  <= kind_nxt;
    op_r    <= op_nxt;
    value_r <= value_nxt;
    err_r   <= err_nxt;
  end

endmodule

// ===== hw/rtl/infix_to_postfix_converter.sv =====
// Top level of the shunting-yard infix to postfix converter.
//
// Input channel in_*: one infix token per transfer. in_tuser carries the token
// kind (operand, operator, open, close, end; other codes are dropped), in_tdata
// carries the operand value and operator code. Output channel out_*: postfix
// results; out_tuser is the result kind, out_tlast marks the final result that
// one input token causes. Tokens are taken one at a time.
// An open parenthesis that fits on the stack, or an operator onto an empty stack,
// is handled in the idle state; an operand passes through the stop state. Other
// tokens read the stack top from the registered stack RAM and pop what they must
// before they finish; results are held one deep so that tlast can be placed.
// A stall on out_tready holds the output register and the hold stage, and the
// sequencer waits; a new token is still taken while a finished result waits
// for its transfer. Reset empties the operator stack and drops any pending
// results; the stack RAM needs no clearing since the stack count guards it.
module infix_to_postfix_converter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] operand_value, [33:32] operator_code, rest zero
  input  logic [ifp_pkg::IN_DATA_W-1:0]   in_tdata,
  // [2:0] token_kind
  input  logic [ifp_pkg::KIND_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] out_value, [33:32] out_operator, [35:34] error_code, rest zero
  output logic [ifp_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] out_kind
  output logic [ifp_pkg::OKIND_W-1:0]     out_tuser,
  output logic                            out_tlast
);

  logic             ram_we;
  ifp_pkg::ptr_t    ram_waddr;
  ifp_pkg::entry_t  ram_wdata;
  logic             ram_re;
  ifp_pkg::ptr_t    ram_raddr;
  ifp_pkg::entry_t  ram_rdata;
  ifp_pkg::ocmd_t   cmd;
  ifp_pkg::ostat_t  stat;

  ifp_ram #(
    .WIDTH (ifp_pkg::ENTRY_W),
    .DEPTH (ifp_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ifp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  ifp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/ifp_chk.sv =====
// Port-level checks for the infix to postfix converter, bound to the top level.
module ifp_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ifp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [ifp_pkg::OKIND_W-1:0]     out_tuser
);

  localparam int OP_LO  = ifp_pkg::VALUE_W;
  localparam int ERR_LO = ifp_pkg::VALUE_W + ifp_pkg::OP_W;

  logic [ifp_pkg::ERR_W-1:0] err_code;
  logic [ifp_pkg::OP_W-1:0]  op_code;

  assign err_code = out_tdata[ERR_LO +: ifp_pkg::ERR_W];
  assign op_code  = out_tdata[OP_LO +: ifp_pkg::OP_W];

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ifp_pkg::RK_ERROR |->
      (err_code == ifp_pkg::ERR_CLOSE || err_code == ifp_pkg::ERR_OVERFLOW))
    else $error("error result with bad code");

  a_end_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ifp_pkg::RK_END |->
      (err_code == ifp_pkg::ERR_NONE || err_code == ifp_pkg::ERR_OPEN) &&
      op_code == '0)
    else $error("end marker with bad fields");

  a_operand_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ifp_pkg::RK_OPERAND |->
      op_code == '0 && err_code == ifp_pkg::ERR_NONE)
    else $error("operand result with stray operator or error");

endmodule

bind infix_to_postfix_converter ifp_chk u_ifp_chk (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the infix to postfix converter stream block.
module testbench;
  import ifp_pkg::*;

  localparam logic [OP_W-1:0] OP_PLUS   = 2'd0;
  localparam logic [OP_W-1:0] OP_MINUS  = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMES  = 2'd2;
  localparam logic [OP_W-1:0] OP_DIVIDE = 2'd3;
  localparam logic [KIND_W-1:0] TK_BAD_LO = 3'd5;
  localparam logic [KIND_W-1:0] TK_BAD_HI = 3'd7;
  localparam int RANDOM_ITEMS = 160;
  localparam int PHASES       = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 3000;

  typedef struct {
    logic [OKIND_W-1:0] kind;
    logic [VALUE_W-1:0] value;
    logic [OP_W-1:0]    op;
    logic [ERR_W-1:0]   err;
    logic               last;
  } postfix_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [OP_W-1:0]    op;
  } token_t;

  typedef struct {
    token_t             tok;
    int                 reps;
    logic               typed;
    logic [OKIND_W-1:0] want_kind;
    logic [VALUE_W-1:0] want_value;
    logic [ERR_W-1:0]   want_err;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OKIND_W-1:0]    out_tuser;
  logic                  out_tlast;

  postfix_t  postfix_q[$];
  postfix_t  step_postfix[$];
  token_t    tok_q[$];
  stim_row_t stim_rows[$];
  entry_t    op_stack[STACK_DEPTH];
  int        op_depth = 0;
  int        fails = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        idle_cycles = 0;
  int        random_sent = 0;

  infix_to_postfix_converter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_result(input logic [OKIND_W-1:0] kind,
                                     input logic [VALUE_W-1:0] value,
                                     input logic [OP_W-1:0] op,
                                     input logic [ERR_W-1:0] err);
    postfix_t r;
    r.kind  = kind;
    r.value = value;
    r.op    = op;
    r.err   = err;
    r.last  = 1'b0;
    step_postfix.push_back(r);
  endfunction

  function automatic void push_entry(input entry_t e);
    if (op_depth >= STACK_DEPTH) begin
      add_result(RK_ERROR, '0, '0, ERR_OVERFLOW);
    end else begin
      op_stack[op_depth] = e;
      op_depth++;
    end
  endfunction

  function automatic void predict_postfix(input token_t t);
    entry_t           top;
    logic             matched;
    logic [ERR_W-1:0] end_err;
    step_postfix.delete();
    matched = 1'b0;
    end_err = ERR_NONE;
    case (t.kind)
      TK_OPERAND: add_result(RK_OPERAND, t.value, '0, ERR_NONE);
      TK_OPERATOR: begin
        // pop while the stacked operator binds at least as tightly
        while (op_depth > 0 && op_stack[op_depth-1] != ENTRY_OPEN &&
               !(op_stack[op_depth-1] < 3'd2 && t.op >= OP_TIMES)) begin
          op_depth--;
          add_result(RK_OPERATOR, '0, op_stack[op_depth][OP_W-1:0], ERR_NONE);
        end
        push_entry(entry_t'(t.op));
      end
      TK_OPEN: push_entry(ENTRY_OPEN);
      TK_CLOSE: begin
        while (op_depth > 0 && !matched) begin
          op_depth--;
          top = op_stack[op_depth];
          if (top == ENTRY_OPEN) matched = 1'b1;
          else add_result(RK_OPERATOR, '0, top[OP_W-1:0], ERR_NONE);
        end
        if (!matched) add_result(RK_ERROR, '0, '0, ERR_CLOSE);
      end
      TK_END: begin
        while (op_depth > 0) begin
          op_depth--;
          top = op_stack[op_depth];
          if (top == ENTRY_OPEN) end_err = ERR_OPEN;
          else add_result(RK_OPERATOR, '0, top[OP_W-1:0], ERR_NONE);
        end
        add_result(RK_END, '0, '0, end_err);
      end
      default: ;
    endcase
    if (step_postfix.size() > 0) step_postfix[step_postfix.size()-1].last = 1'b1;
  endfunction

  task automatic send_token(input token_t t, input logic keep);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= t.kind;
    in_tdata  <= {{(IN_DATA_W-VALUE_W-OP_W){1'b0}}, t.op, t.value};
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_postfix(t);
    if (keep) foreach (step_postfix[i]) postfix_q.push_back(step_postfix[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (postfix_q.size() > 0) @(posedge clk);
  endtask

  function automatic void add_row(input logic [KIND_W-1:0] kind,
                                  input logic [VALUE_W-1:0] value,
                                  input logic [OP_W-1:0] op, input int reps,
                                  input logic typed,
                                  input logic [OKIND_W-1:0] want_kind,
                                  input logic [VALUE_W-1:0] want_value,
                                  input logic [ERR_W-1:0] want_err);
    stim_row_t r;
    r.tok.kind   = kind;
    r.tok.value  = value;
    r.tok.op     = op;
    r.reps       = reps;
    r.typed      = typed;
    r.want_kind  = want_kind;
    r.want_value = want_value;
    r.want_err   = want_err;
    stim_rows.push_back(r);
  endfunction

  function automatic void push_tok(input logic [KIND_W-1:0] kind);
    token_t t;
    t.kind  = kind;
    t.value = $urandom;
    t.op    = OP_W'($urandom_range(3));
    tok_q.push_back(t);
  endfunction

  function automatic void build_expression();
    int depth;
    int terms;
    int nest;
    tok_q.delete();
    depth = 0;
    // deep nesting now and then, to reach the full stack
    if ($urandom_range(7) == 0) begin
      nest = $urandom_range(18, 12);
      repeat (nest) push_tok(TK_OPEN);
      depth = nest;
    end
    terms = $urandom_range(6, 1);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) push_tok(TK_OPERATOR);
      while ($urandom_range(3) == 0) begin
        push_tok(TK_OPEN);
        depth++;
      end
      push_tok(TK_OPERAND);
      while (depth > 0 && $urandom_range(2) == 0) begin
        push_tok(TK_CLOSE);
        depth--;
      end
    end
    while (depth > 0) begin
      push_tok(TK_CLOSE);
      depth--;
    end
    push_tok(TK_END);
  endfunction

  function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    postfix_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (postfix_q.size() == 0) begin
        $error("unexpected result: kind %0d tdata 0x%0h", out_tuser, out_tdata);
        fails++;
      end else begin
        want = postfix_q.pop_front();
        check_field("out_kind", VALUE_W'(want.kind), VALUE_W'(out_tuser));
        check_field("out_value", want.value, out_tdata[VALUE_W-1:0]);
        check_field("out_operator", VALUE_W'(want.op),
                    VALUE_W'(out_tdata[VALUE_W+OP_W-1:VALUE_W]));
        check_field("error_code", VALUE_W'(want.err),
                    VALUE_W'(out_tdata[VALUE_W+OP_W+ERR_W-1:VALUE_W+OP_W]));
        check_field("tdata_pad", '0,
                    VALUE_W'(out_tdata[OUT_DATA_W-1:VALUE_W+OP_W+ERR_W]));
        check_field("out_tlast", VALUE_W'(want.last), VALUE_W'(out_tlast));
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    token_t    noise;
    postfix_t  want;
    int        r;
    int        idle_set[PHASES]  = '{0, 50, 0, 32};
    int        stall_set[PHASES] = '{0, 0, 50, 32};

    add_row(TK_CLOSE,   32'd0,          OP_PLUS,   1,  1'b1, RK_ERROR,   '0, ERR_CLOSE);
    add_row(TK_END,     32'd0,          OP_PLUS,   1,  1'b1, RK_END,     '0, ERR_NONE);
    add_row(TK_OPERAND, 32'd0,          OP_DIVIDE, 1,  1'b1, RK_OPERAND, 32'd0, ERR_NONE);
    add_row(TK_OPERAND, 32'hFFFF_FFFF,  OP_DIVIDE, 1,  1'b1, RK_OPERAND, 32'hFFFF_FFFF,
            ERR_NONE);
    add_row(TK_OPERAND, 32'd5,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPERATOR, 32'hFFFF_FFFF, OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPERAND, 32'd7,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPERATOR, 32'd0,         OP_TIMES,  1,  1'b0, '0, '0, '0);
    add_row(TK_OPERAND, 32'd9,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPERATOR, 32'd0,         OP_MINUS,  1,  1'b0, '0, '0, '0);
    add_row(TK_OPEN,    32'd0,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPERAND, 32'd2,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPERATOR, 32'd0,         OP_DIVIDE, 1,  1'b0, '0, '0, '0);
    add_row(TK_OPERAND, 32'd4,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPERATOR, 32'd0,         OP_TIMES,  1,  1'b0, '0, '0, '0);
    add_row(TK_OPERAND, 32'd3,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_CLOSE,   32'd0,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_BAD_LO,  32'hFFFF_FFFF,  OP_DIVIDE, 1,  1'b0, '0, '0, '0);
    add_row(TK_BAD_HI,  32'hFFFF_FFFF,  OP_DIVIDE, 1,  1'b0, '0, '0, '0);
    add_row(TK_END,     32'd0,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPERAND, 32'd1,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPERATOR, 32'd0,         OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_CLOSE,   32'd0,          OP_PLUS,   1,  1'b0, '0, '0, '0);
    add_row(TK_OPEN,    32'd0,          OP_PLUS,   STACK_DEPTH, 1'b0, '0, '0, '0);
    add_row(TK_OPEN,    32'd0,          OP_PLUS,   1,  1'b1, RK_ERROR,   '0, ERR_OVERFLOW);
    add_row(TK_OPERATOR, 32'd0,         OP_DIVIDE, 1,  1'b1, RK_ERROR,   '0, ERR_OVERFLOW);
    add_row(TK_END,     32'd0,          OP_PLUS,   1,  1'b1, RK_END,     '0, ERR_OPEN);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      repeat (stim_rows[i].reps) begin
        send_token(stim_rows[i].tok, !stim_rows[i].typed);
        if (stim_rows[i].typed) begin
          want.kind  = stim_rows[i].want_kind;
          want.value = stim_rows[i].want_value;
          want.op    = '0;
          want.err   = stim_rows[i].want_err;
          want.last  = 1'b1;
          postfix_q.push_back(want);
        end
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      while (random_sent < RANDOM_ITEMS * (p + 1) / PHASES) begin
        build_expression();
        foreach (tok_q[i]) begin
          r = $urandom_range(99);
          // drop a token or slip in a stray one
          if (r < 5) continue;
          if (r < 13) begin
            noise.kind  = KIND_W'($urandom_range(7));
            noise.value = $urandom;
            noise.op    = OP_W'($urandom_range(3));
            send_token(noise, 1'b1);
            if (noise.kind <= TK_END) random_sent++;
          end
          send_token(tok_q[i], 1'b1);
          random_sent++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ifp_pkg.sv
hw/rtl/ifp_ram.sv
hw/rtl/ifp_out.sv
hw/rtl/ifp_ctrl.sv
hw/rtl/infix_to_postfix_converter.sv
hw/rtl/ifp_chk.sv
test/testbench.sv
